FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the scan unit and the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the next cycle
`define SHA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps

package sha_pkg;

   // request codes
   localparam logic [1:0] REQ_CHECK = 2'd0;
   localparam logic [1:0] REQ_ALLOC = 2'd1;
   localparam logic [1:0] REQ_ADD   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_COMPACT = 2'd1;
   localparam logic [1:0] ST_OOM     = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // fit policies
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [0:0] CSR_IDX_FIT_POLICY = 1'b0;

   localparam int FIELD_BITS = 16;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [FIELD_BITS-1:0] request_size;
      logic [FIELD_BITS-1:0] hole_start;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [FIELD_BITS-1:0] segment_base;
   } rsp_item_type;

   typedef struct packed {
      logic       start;
      logic [1:0] policy;
   } scan_ctrl_type;

   typedef struct packed {
      logic pick_found;
      logic free_found;
      logic total_covers;
   } scan_flags_type;

endpackage

FILE: hw/rtl/sha_hole_mem.sv
`timescale 1ns / 1ps

module sha_hole_mem import sha_pkg::*; #(
   parameter int HOLE_SLOTS = 32,
   parameter int ADDR_BITS  = 16,
   localparam int IDX_BITS  = $clog2(HOLE_SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [IDX_BITS-1:0]  wr_addr,
   input  logic                 wr_valid,
   input  logic [ADDR_BITS-1:0] wr_size,
   input  logic [ADDR_BITS-1:0] wr_base,
   input  logic                 rd_en,
   input  logic [IDX_BITS-1:0]  rd_addr,
   output logic                 rd_hit,
   output logic [IDX_BITS-1:0]  rd_index,
   output logic                 rd_valid,
   output logic [ADDR_BITS-1:0] rd_size,
   output logic [ADDR_BITS-1:0] rd_base
);

   localparam int WORD_BITS = 2 * ADDR_BITS + 1;

   logic [WORD_BITS-1:0] mem [HOLE_SLOTS];
   logic [WORD_BITS-1:0] rd_word_ff;
   logic [IDX_BITS-1:0]  rd_index_ff;
   logic                 rd_hit_ff;

   // word layout: valid, size, base
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_valid, wr_size, wr_base};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff  <= mem[rd_addr];
         rd_index_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_hit_ff <= 1'b0;
      end else begin
         rd_hit_ff <= rd_en;
      end
   end

   assign rd_hit   = rd_hit_ff;
   assign rd_index = rd_index_ff;
   assign rd_valid = rd_word_ff[WORD_BITS-1];
   assign rd_size  = rd_word_ff[2*ADDR_BITS-1:ADDR_BITS];
   assign rd_base  = rd_word_ff[ADDR_BITS-1:0];

endmodule

FILE: hw/rtl/sha_scan_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha_scan_unit import sha_pkg::*; #(
   parameter int HOLE_SLOTS = 32,
   parameter int ADDR_BITS  = 16,
   localparam int IDX_BITS  = $clog2(HOLE_SLOTS),
   localparam int SUM_BITS  = ADDR_BITS + $clog2(HOLE_SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  scan_ctrl_type        ctrl,
   input  logic [ADDR_BITS-1:0] need,
   input  logic                 ent_hit,
   input  logic [IDX_BITS-1:0]  ent_index,
   input  logic                 ent_valid,
   input  logic [ADDR_BITS-1:0] ent_size,
   input  logic [ADDR_BITS-1:0] ent_base,
   output scan_flags_type       flags,
   output logic [IDX_BITS-1:0]  pick_slot,
   output logic [ADDR_BITS-1:0] pick_size,
   output logic [ADDR_BITS-1:0] pick_base,
   output logic [IDX_BITS-1:0]  free_slot
);

   logic                 pick_found_ff, pick_found_in;
   logic [IDX_BITS-1:0]  pick_slot_ff, pick_slot_in;
   logic [ADDR_BITS-1:0] pick_size_ff, pick_size_in;
   logic [ADDR_BITS-1:0] pick_base_ff, pick_base_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]  free_slot_ff, free_slot_in;
   logic [SUM_BITS-1:0]  total_ff, total_in;

   logic fits;
   logic size_lt;
   logic size_gt;
   logic size_eq;
   logic base_lt;
   logic better;
   logic take;

   // shared compare unit, one entry per cycle
   always_comb begin
      fits    = ent_valid && (ent_size >= need);
      size_lt = ent_size < pick_size_ff;
      size_gt = ent_size > pick_size_ff;
      size_eq = ent_size == pick_size_ff;
      base_lt = ent_base < pick_base_ff;
      case (ctrl.policy)
         FIT_BEST:  better = size_lt || (size_eq && base_lt);
         FIT_WORST: better = size_gt || (size_eq && base_lt);
         default:   better = base_lt;
      endcase
      take = fits && (!pick_found_ff || better);
   end

   always_comb begin
      pick_found_in = pick_found_ff;
      pick_slot_in  = pick_slot_ff;
      pick_size_in  = pick_size_ff;
      pick_base_in  = pick_base_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      total_in      = total_ff;
      if (ctrl.start) begin
         pick_found_in = 1'b0;
         free_found_in = 1'b0;
         total_in      = '0;
      end else if (ent_hit) begin
         if (take) begin
            pick_found_in = 1'b1;
            pick_slot_in  = ent_index;
            pick_size_in  = ent_size;
            pick_base_in  = ent_base;
         end
         if (!ent_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = ent_index;
         end
         if (ent_valid) begin
            total_in = total_ff + SUM_BITS'(ent_size);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         total_ff      <= '0;
      end else begin
         pick_found_ff <= pick_found_in;
         free_found_ff <= free_found_in;
         total_ff      <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_slot_ff <= pick_slot_in;
      pick_size_ff <= pick_size_in;
      pick_base_ff <= pick_base_in;
      free_slot_ff <= free_slot_in;
   end

   assign flags.pick_found   = pick_found_ff;
   assign flags.free_found   = free_found_ff;
   assign flags.total_covers = total_ff >= SUM_BITS'(need);
   assign pick_slot          = pick_slot_ff;
   assign pick_size          = pick_size_ff;
   assign pick_base          = pick_base_ff;
   assign free_slot          = free_slot_ff;

   // a chosen hole always holds the request
   `SHA_ASSERT_NOW(a_pick_fits, clock, reset, pick_found_ff && !ctrl.start,
      pick_size_ff >= need, "chosen hole smaller than request")

   // a new walk begins with no pick, no free slot and a zero total
   `SHA_ASSERT_NEXT(a_start_clears, clock, reset, ctrl.start,
      !pick_found_ff && !free_found_ff && total_ff == '0, "scan state not cleared at start")

   // an entry that wins the compare leaves a pick behind
   `SHA_ASSERT_NEXT(a_take_kept, clock, reset, ent_hit && take && !ctrl.start,
      pick_found_ff, "taken entry not recorded")

endmodule

FILE: hw/rtl/segment_hole_allocator.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// segment hole allocator: a table of free holes (base, size, valid) in one memory
// req channel: valid/ready, one item per request (check space, allocate, add hole)
// rsp channel: valid/ready, exactly one item per request, in request order
// csr port: apb-style, fit_policy at byte address 0, pready tied high
// every request walks all HOLE_SLOTS table entries through the single read port
// of the hole memory, one entry per cycle, feeding one shared compare unit
// an accepted item goes through S_SCAN, S_DRAIN and S_FINISH, where its result is
// registered once the output register is free; one request in flight at a time
// after reset all HOLE_SLOTS entries are swept clear, one entry per cycle;
// req_ready stays low until the sweep ends, csr writes are taken throughout
// a held result sits in the output register; the next item is accepted meanwhile
// and its scan runs, but its result and table update wait until rsp is taken
module segment_hole_allocator import sha_pkg::*; #(
   parameter int HOLE_SLOTS = 32,
   parameter int ADDR_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_item_type             rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int IDX_BITS = $clog2(HOLE_SLOTS);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(HOLE_SLOTS - 1);

   // sequencer state and per-item registers
   seq_state_type        state_ff, state_in;
   logic [IDX_BITS-1:0]  cnt_ff, cnt_in;
   logic [1:0]           kind_ff;
   logic [ADDR_BITS-1:0] need_ff;
   logic [ADDR_BITS-1:0] start_ff;
   logic [1:0]           policy_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_data_ff, rsp_data_in;

   // memory ports
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   logic                 wr_valid;
   logic [ADDR_BITS-1:0] wr_size;
   logic [ADDR_BITS-1:0] wr_base;
   logic                 rd_en;
   logic                 rd_hit;
   logic [IDX_BITS-1:0]  rd_index;
   logic                 rd_valid;
   logic [ADDR_BITS-1:0] rd_size;
   logic [ADDR_BITS-1:0] rd_base;

   // scan unit
   scan_ctrl_type        scan_ctrl;
   scan_flags_type       scan_flags;
   logic [IDX_BITS-1:0]  pick_slot;
   logic [ADDR_BITS-1:0] pick_size;
   logic [ADDR_BITS-1:0] pick_base;
   logic [IDX_BITS-1:0]  free_slot;

   logic                 accept;
   logic                 csr_write;
   logic                 can_load;
   logic [1:0]           shortage;
   logic [ADDR_BITS-1:0] left_size;

   assign accept    = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite
                      && (paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_FIT_POLICY);
   assign pready    = 1'b1;
   assign prdata    = (paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_FIT_POLICY)
                      ? {{(CSR_DATA_BITS-2){1'b0}}, policy_ff} : '0;

   // policy register
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= FIT_FIRST;
      end else if (csr_write) begin
         policy_ff <= pwdata[1:0];
      end
   end

   // request fields, resized to the table width
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_data.req_type;
         need_ff  <= ADDR_BITS'(req_data.request_size);
         start_ff <= ADDR_BITS'(req_data.hole_start);
      end
   end

   // space checks only ask whether some hole fits, so first fit serves them
   assign scan_ctrl.start  = accept;
   assign scan_ctrl.policy = (kind_ff == REQ_ALLOC) ? policy_ff : FIT_FIRST;

   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign shortage  = scan_flags.total_covers ? ST_COMPACT : ST_OOM;
   assign left_size = pick_size - need_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_valid     = 1'b0;
      wr_size      = need_ff;
      wr_base      = start_ff;

      // result taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // post-reset sweep marks every slot free
            wr_en = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cnt_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // one table read per cycle, evaluated the cycle after
            rd_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last entry is in the compare unit
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (can_load) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = ST_OK;
               rsp_data_in.segment_base = '0;
               state_in                 = S_IDLE;
               case (kind_ff)
                  REQ_CHECK: begin
                     if (!scan_flags.pick_found) begin
                        rsp_data_in.status = shortage;
                     end
                  end
                  REQ_ALLOC: begin
                     if (scan_flags.pick_found) begin
                        rsp_data_in.segment_base = FIELD_BITS'(pick_base);
                        // shrink the hole, free it when nothing is left
                        wr_en    = 1'b1;
                        wr_addr  = pick_slot;
                        wr_valid = left_size != '0;
                        wr_size  = left_size;
                        wr_base  = pick_base + need_ff;
                     end else begin
                        rsp_data_in.status = shortage;
                     end
                  end
                  REQ_ADD: begin
                     // zero-size add is ignored
                     if (need_ff != '0) begin
                        if (scan_flags.free_found) begin
                           wr_en    = 1'b1;
                           wr_addr  = free_slot;
                           wr_valid = 1'b1;
                        end else begin
                           rsp_data_in.status = ST_FULL;
                        end
                     end
                  end
                  default: begin
                     // unused request type changes nothing
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sha_hole_mem #(
      .HOLE_SLOTS (HOLE_SLOTS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_valid (wr_valid),
      .wr_size  (wr_size),
      .wr_base  (wr_base),
      .rd_en    (rd_en),
      .rd_addr  (cnt_ff),
      .rd_hit   (rd_hit),
      .rd_index (rd_index),
      .rd_valid (rd_valid),
      .rd_size  (rd_size),
      .rd_base  (rd_base)
   );

   sha_scan_unit #(
      .HOLE_SLOTS (HOLE_SLOTS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .need      (need_ff),
      .ent_hit   (rd_hit),
      .ent_index (rd_index),
      .ent_valid (rd_valid),
      .ent_size  (rd_size),
      .ent_base  (rd_base),
      .flags     (scan_flags),
      .pick_slot (pick_slot),
      .pick_size (pick_size),
      .pick_base (pick_base),
      .free_slot (free_slot)
   );

   // a new item always starts its walk at slot zero
   `SHA_ASSERT_NEXT(a_scan_start, clock, reset, accept,
      state_ff == S_SCAN && cnt_ff == '0, "scan did not start at slot zero")

   // the table only changes during the sweep or when a result is produced
   `SHA_ASSERT_NOW(a_write_window, clock, reset, wr_en,
      state_ff == S_CLEAR || (state_ff == S_FINISH && can_load),
      "table written outside the sweep or result cycle")

   // the walk must be fully evaluated before a result is formed
   `SHA_ASSERT_NOW(a_scan_drained, clock, reset, state_ff == S_FINISH,
      !rd_hit && !rd_en, "result formed with a table read in flight")

endmodule
